### design/csep_pkg.sv
`timescale 1ns / 1ps
package csep_pkg;

	localparam int unsigned CoordW = 14;
	localparam int unsigned ChanW = 8;
	localparam logic [7:0] ChanScale = 8'd255;
	localparam int unsigned RedShift = 16;
	localparam int unsigned GreenShift = 8;

	typedef struct packed {
		logic              compressed;
		logic [31:0]       word_x;
		logic [31:0]       word_y;
		logic [31:0]       word_z;
		logic [CoordW-1:0] pixel_x;
		logic [CoordW-1:0] pixel_y;
	} csep_in_t;

	typedef struct packed {
		logic [23:0]       color;
		logic [CoordW-1:0] out_x;
		logic [CoordW-1:0] out_y;
	} csep_out_t;

endpackage

### design/shader_color_export_pack.sv
`timescale 1ns / 1ps
// an accepted input beat passes the stage-1 and stage-2 registers to reach its output beat
// throughput: one beat per cycle while out_stall holds no output beat, set by three channel lanes in a two-stage pipe
// the whole pipe holds while an output beat waits under stall
// reset clears the valid bits only; payload registers are not reset
module shader_color_export_pack (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  csep_pkg::csep_in_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output csep_pkg::csep_out_t out_data
);
	import csep_pkg::*;

	logic              en;
	logic              valid_s1;
	logic              valid_s2;
	logic [CoordW-1:0] x_s1;
	logic [CoordW-1:0] y_s1;
	logic [CoordW-1:0] x_s2;
	logic [CoordW-1:0] y_s2;
	logic [31:0]       red_bits;
	logic [31:0]       grn_bits;
	logic [31:0]       blu_bits;
	logic [ChanW-1:0]  red_byte;
	logic [ChanW-1:0]  grn_byte;
	logic [ChanW-1:0]  blu_byte;

	assign en = !(valid_s2 && out_stall);
	assign in_stall = !en;

	always_comb begin
		if (in_data.compressed) begin
			red_bits = {16'b0, in_data.word_x[15:0]};
			grn_bits = {16'b0, in_data.word_x[31:16]};
			blu_bits = {16'b0, in_data.word_y[15:0]};
		end else begin
			red_bits = in_data.word_x;
			grn_bits = in_data.word_y;
			blu_bits = in_data.word_z;
		end
	end

	csep_lane u_red (.clk(clk), .en(en), .is_half(in_data.compressed),
		.bits(red_bits), .chan_byte(red_byte));
	csep_lane u_grn (.clk(clk), .en(en), .is_half(in_data.compressed),
		.bits(grn_bits), .chan_byte(grn_byte));
	csep_lane u_blu (.clk(clk), .en(en), .is_half(in_data.compressed),
		.bits(blu_bits), .chan_byte(blu_byte));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= in_data.pixel_x;
			y_s1 <= in_data.pixel_y;
			x_s2 <= x_s1;
			y_s2 <= y_s1;
		end
	end

	// merge the lane bytes into one rgb888 word
	assign out_valid = valid_s2;
	assign out_data.color = ({16'b0, red_byte} << RedShift) | ({16'b0, grn_byte} << GreenShift)
		| {16'b0, blu_byte};
	assign out_data.out_x = x_s2;
	assign out_data.out_y = y_s2;

endmodule

### design/csep_lane.sv
`timescale 1ns / 1ps
module csep_lane (
	input  logic        clk,
	input  logic        en,
	input  logic        is_half,
	input  logic [31:0] bits,
	output logic [csep_pkg::ChanW-1:0] chan_byte
);
	import csep_pkg::*;

	logic        sgn;
	logic [7:0]  ex;
	logic [23:0] mant;
	logic        zero_c;
	logic        sat_c;
	logic [31:0] prod;

	logic        zero_s1;
	logic        sat_s1;
	logic [31:0] prod_s1;
	logic [7:0]  ex_s1;

	logic        top;
	logic        rnd;
	logic        sticky;
	logic        lsb;
	logic [32:0] base;
	logic [32:0] rounded;
	logic [7:0]  sh;
	logic [32:0] whole;

	// decode into sign, biased single exponent and significand
	always_comb begin
		zero_c = 1'b0;
		sat_c = 1'b0;
		if (is_half) begin
			sgn = bits[15];
			ex = {3'b000, bits[14:10]} + 8'd112;
			mant = {1'b1, bits[9:0], 13'b0};
			// half subnormals scale to below one
			if (bits[14:10] == 5'd0)
				zero_c = 1'b1;
			if (bits[14:10] == 5'h1f) begin
				if (bits[9:0] != 10'd0)
					zero_c = 1'b1;
				else
					sat_c = 1'b1;
			end
		end else begin
			sgn = bits[31];
			ex = bits[30:23];
			mant = {1'b1, bits[22:0]};
			if (ex == 8'd0)
				zero_c = 1'b1;
			if (ex == 8'hff) begin
				if (bits[22:0] != 23'd0)
					zero_c = 1'b1;
				else
					sat_c = 1'b1;
			end
		end
		if (sgn)
			zero_c = 1'b1;
		// one or more times 255 is at least 255
		if (ex >= 8'd127)
			sat_c = 1'b1;
		prod = mant * ChanScale;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= zero_c;
			sat_s1 <= sat_c;
			prod_s1 <= prod;
			ex_s1 <= ex;
		end
	end

	// round product to 24 significant bits, nearest even
	always_comb begin
		top = prod_s1[31];
		if (top) begin
			rnd = prod_s1[7];
			sticky = |prod_s1[6:0];
			lsb = prod_s1[8];
			base = {1'b0, prod_s1[31:8], 8'b0};
		end else begin
			rnd = prod_s1[6];
			sticky = |prod_s1[5:0];
			lsb = prod_s1[7];
			base = {2'b00, prod_s1[30:7], 7'b0};
		end
		rounded = base;
		if (rnd && (sticky || lsb))
			rounded = base + (top ? 33'd256 : 33'd128);
		sh = 8'd150 - ex_s1;
		whole = rounded >> sh;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s1)
				chan_byte <= '0;
			else if (sat_s1 || whole >= 33'd255)
				chan_byte <= 8'd255;
			else
				chan_byte <= whole[ChanW-1:0];
		end
	end

endmodule
